// File: rtl/sensorless_bldc_commutation_macros.svh
// ----------------------------------------------------------------------------
// sensorless_bldc_commutation_macros
// assertion macros shared by the commutation block
// ----------------------------------------------------------------------------
`ifndef SENSORLESS_BLDC_COMMUTATION_MACROS_SVH
`define SENSORLESS_BLDC_COMMUTATION_MACROS_SVH

// same-cycle implication
`define SBLDC_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBLDC_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbldc_pkg.sv
// ----------------------------------------------------------------------------
// sbldc_pkg
// types, constants and drive tables of the sensorless commutation block
// ----------------------------------------------------------------------------
package sbldc_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int TIMER_BITS_DEF    = 16;

  localparam int SUM_W      = 16;
  localparam int IV_W       = 15;
  localparam int AVG_W      = 12;
  localparam int DUTY_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int TOUT_W     = 8;
  localparam int OFFS_W     = 12;
  localparam int STEP_W     = 3;
  localparam int PHASE_W    = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [IV_W-1:0]    IV_MAX            = 15'h7fff;
  localparam logic [IV_W-1:0]    OVERFLOW_INTERVAL = 15'h1fff;
  localparam logic [IV_W-1:0]    START_INTERVAL    = 15'd400;
  localparam logic [AVG_W-1:0]   VALID_LIMIT       = 12'd1000;
  localparam logic [COUNT_W-1:0] SHORT_DELAY       = 16'd40;
  localparam logic [STEP_W-1:0]  LAST_STEP         = 3'd5;

  localparam logic [DUTY_W-1:0]  TARGET_DUTY_RST    = 8'd100;
  localparam logic [DUTY_W-1:0]  START_DUTY_RST     = 8'd30;
  localparam logic [TOUT_W-1:0]  TIMEOUT_RELOAD_RST = 8'd125;
  localparam logic [COUNT_W-1:0] BLANK_TICKS_RST    = 16'd80;
  localparam logic [OFFS_W-1:0]  DELAY_OFFSET_RST   = 12'd40;

  typedef enum logic [1:0] {
    OP_FAST  = 2'd0,
    OP_SLOW  = 2'd1,
    OP_START = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TARGET_DUTY    = 3'd0,
    REG_START_DUTY     = 3'd1,
    REG_TIMEOUT_RELOAD = 3'd2,
    REG_BLANK_TICKS    = 3'd3,
    REG_DELAY_OFFSET   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    BL_ARMED = 3'b001,
    BL_WAIT  = 3'b010,
    BL_BLANK = 3'b100
  } blank_fsm_t;

  localparam logic [1:0] BLANK_CODE_ARMED = 2'd0;
  localparam logic [1:0] BLANK_CODE_WAIT  = 2'd1;
  localparam logic [1:0] BLANK_CODE_BLANK = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              comparator;
    logic [STEP_W-1:0] start_step;
  } sbldc_in_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_now;
    logic [PHASE_W-1:0] high_side;
    logic [PHASE_W-1:0] low_side;
    logic [DUTY_W-1:0]  duty;
    logic [1:0]         sense_phase;
    logic               is_running;
    logic               commutated;
    logic               timed_out;
    logic [AVG_W-1:0]   avg_interval;
    logic [1:0]         blank_state;
  } sbldc_out_t;

  typedef struct packed {
    logic push;
    logic fill;
  } hist_ctrl_t;

  function automatic logic [1:0] blank_code(blank_fsm_t s);
    logic [1:0] c;
    case (s)
      BL_WAIT:  c = BLANK_CODE_WAIT;
      BL_BLANK: c = BLANK_CODE_BLANK;
      default:  c = BLANK_CODE_ARMED;
    endcase
    return c;
  endfunction

  function automatic logic [PHASE_W-1:0] high_bits(logic [STEP_W-1:0] s);
    logic [PHASE_W-1:0] b;
    case (s)
      3'd2, 3'd3: b = 3'b010;
      3'd4, 3'd5: b = 3'b100;
      default:    b = 3'b001;
    endcase
    return b;
  endfunction

  function automatic logic [PHASE_W-1:0] low_bits(logic [STEP_W-1:0] s);
    logic [PHASE_W-1:0] b;
    case (s)
      3'd1, 3'd2: b = 3'b100;
      3'd3, 3'd4: b = 3'b001;
      default:    b = 3'b010;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] sense_bits(logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd1, 3'd4: p = 2'd1;
      3'd2, 3'd5: p = 2'd0;
      default:    p = 2'd2;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/sbldc_stream_if.sv
// ----------------------------------------------------------------------------
// sbldc_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface sbldc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sbldc_hist.sv
// ----------------------------------------------------------------------------
// sbldc_hist
// crossing interval history with running sum and half-average
// ----------------------------------------------------------------------------
module sbldc_hist #(
  parameter int HISTORY_DEPTH = sbldc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbldc_pkg::hist_ctrl_t        ctrl,
  input  logic [sbldc_pkg::IV_W-1:0]   iv,
  output logic [sbldc_pkg::AVG_W-1:0]  avg
);
  localparam int POS_W     = $clog2(HISTORY_DEPTH);
  localparam int DIV       = 2 * HISTORY_DEPTH;
  localparam int DIV_SHIFT = sbldc_pkg::SUM_W + $clog2(DIV);
  localparam int PROD_W    = sbldc_pkg::SUM_W + DIV_SHIFT + 1;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << DIV_SHIFT) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [DIV_SHIFT:0] RECIP = (DIV_SHIFT + 1)'(RECIP_L);
  localparam logic [sbldc_pkg::SUM_W-1:0] FILL_SUM =
    sbldc_pkg::SUM_W'(int'(sbldc_pkg::START_INTERVAL) * HISTORY_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);

  logic [sbldc_pkg::IV_W-1:0]  hist [HISTORY_DEPTH];
  logic [sbldc_pkg::SUM_W-1:0] sum;
  logic [sbldc_pkg::SUM_W-1:0] sum_next;
  logic [POS_W-1:0]            pos;
  logic [PROD_W-1:0]           prod;

  assign sum_next = sum - sbldc_pkg::SUM_W'(hist[pos]) + sbldc_pkg::SUM_W'(iv);

  // divide by twice the depth through a rounded-up reciprocal
  assign prod = PROD_W'(sum_next) * PROD_W'(RECIP);
  assign avg  = prod[DIV_SHIFT +: sbldc_pkg::AVG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      pos <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (ctrl.fill) begin
      sum <= FILL_SUM;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= sbldc_pkg::START_INTERVAL;
      end
    end else if (ctrl.push) begin
      sum       <= sum_next;
      hist[pos] <= iv;
      pos       <= (pos == LAST_POS) ? '0 : pos + 1'b1;
    end
  end

endmodule

// File: rtl/sensorless_bldc_commutation.sv
// ----------------------------------------------------------------------------
// sensorless_bldc_commutation
// six-step sensorless commutation from back-EMF zero crossings
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result register is not stalled,
// and returns one result beat for each: a beat lands in an input register,
// and its whole state update is written with the result register as it
// leaves. The running interval sum and its reciprocal multiply set the
// longest path. A stalled result register holds one beat while the input
// register takes the next. All state clears at reset with no clearing pass.
module sensorless_bldc_commutation #(
  parameter int HISTORY_DEPTH = sbldc_pkg::HISTORY_DEPTH_DEF,
  parameter int TIMER_BITS    = sbldc_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  sbldc_stream_if.sink                       item,
  sbldc_stream_if.source                     result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbldc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sbldc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sbldc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);
  `include "sensorless_bldc_commutation_macros.svh"

  localparam int HW = (TIMER_BITS > sbldc_pkg::IV_W) ? TIMER_BITS : sbldc_pkg::IV_W;

  // configuration
  logic [sbldc_pkg::DUTY_W-1:0]  target_duty;
  logic [sbldc_pkg::DUTY_W-1:0]  start_duty;
  logic [sbldc_pkg::TOUT_W-1:0]  timeout_reload;
  logic [sbldc_pkg::COUNT_W-1:0] blank_ticks;
  logic [sbldc_pkg::OFFS_W-1:0]  delay_offset;
  logic                          cfg_write;

  // handshake
  logic                  in_valid;
  sbldc_pkg::sbldc_in_t  in_data;
  logic                  res_valid;
  sbldc_pkg::sbldc_out_t res_data;
  sbldc_pkg::sbldc_out_t res_data_next;
  logic                  proc;

  // state
  logic [sbldc_pkg::STEP_W-1:0]  step_reg, step_reg_next;
  logic                          running, running_next;
  sbldc_pkg::blank_fsm_t         blank_phase, blank_phase_next;
  logic [TIMER_BITS-1:0]         crossing_timer, crossing_timer_next;
  logic                          overflow_seen, overflow_seen_next;
  logic [sbldc_pkg::COUNT_W-1:0] delay_count, delay_count_next;
  logic                          delay_active, delay_active_next;
  logic [sbldc_pkg::TOUT_W-1:0]  timeout_left, timeout_left_next;
  logic [sbldc_pkg::DUTY_W-1:0]  duty_level, duty_level_next;
  logic                          prev_comparator, prev_comparator_next;
  logic [sbldc_pkg::AVG_W-1:0]   last_average, last_average_next;

  // datapath
  logic [TIMER_BITS-1:0]         timer_inc;
  logic                          overflow_hit;
  logic [HW-1:0]                 half_ext;
  logic [sbldc_pkg::IV_W-1:0]    iv_sat;
  logic [sbldc_pkg::IV_W-1:0]    iv_sel;
  logic [sbldc_pkg::AVG_W-1:0]   hist_avg;
  logic                          zc_edge;
  logic                          push_c;
  logic                          fill_c;
  logic                          commutated_c;
  logic                          timed_out_c;
  sbldc_pkg::hist_ctrl_t         hist_ctrl;

  // apb register file
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_duty    <= sbldc_pkg::TARGET_DUTY_RST;
      start_duty     <= sbldc_pkg::START_DUTY_RST;
      timeout_reload <= sbldc_pkg::TIMEOUT_RELOAD_RST;
      blank_ticks    <= sbldc_pkg::BLANK_TICKS_RST;
      delay_offset   <= sbldc_pkg::DELAY_OFFSET_RST;
    end else if (cfg_write) begin
      case (sbldc_pkg::reg_index_t'(paddr[4:2]))
        sbldc_pkg::REG_TARGET_DUTY:    target_duty    <= pwdata[sbldc_pkg::DUTY_W-1:0];
        sbldc_pkg::REG_START_DUTY:     start_duty     <= pwdata[sbldc_pkg::DUTY_W-1:0];
        sbldc_pkg::REG_TIMEOUT_RELOAD: timeout_reload <= pwdata[sbldc_pkg::TOUT_W-1:0];
        sbldc_pkg::REG_BLANK_TICKS:    blank_ticks    <= pwdata[sbldc_pkg::COUNT_W-1:0];
        sbldc_pkg::REG_DELAY_OFFSET:   delay_offset   <= pwdata[sbldc_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sbldc_pkg::reg_index_t'(paddr[4:2]))
      sbldc_pkg::REG_TARGET_DUTY:    prdata = sbldc_pkg::APB_DATA_W'(target_duty);
      sbldc_pkg::REG_START_DUTY:     prdata = sbldc_pkg::APB_DATA_W'(start_duty);
      sbldc_pkg::REG_TIMEOUT_RELOAD: prdata = sbldc_pkg::APB_DATA_W'(timeout_reload);
      sbldc_pkg::REG_BLANK_TICKS:    prdata = sbldc_pkg::APB_DATA_W'(blank_ticks);
      sbldc_pkg::REG_DELAY_OFFSET:   prdata = sbldc_pkg::APB_DATA_W'(delay_offset);
      default:                       prdata = '0;
    endcase
  end

  // input register and result register
  assign proc         = in_valid & (~res_valid | result.ready);
  assign item.ready   = ~in_valid | proc;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.valid & item.ready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (proc) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid & item.ready) begin
      in_data <= item.data;
    end
    if (proc) begin
      res_data <= res_data_next;
    end
  end

  // crossing interval
  assign timer_inc    = crossing_timer + 1'b1;
  assign overflow_hit = overflow_seen | (timer_inc == '0);
  assign half_ext     = HW'(timer_inc >> 1);
  assign iv_sat       = (half_ext > HW'(sbldc_pkg::IV_MAX)) ? sbldc_pkg::IV_MAX
                                                           : half_ext[sbldc_pkg::IV_W-1:0];
  assign iv_sel       = overflow_hit ? sbldc_pkg::OVERFLOW_INTERVAL : iv_sat;
  assign zc_edge      = step_reg[0] ? (~prev_comparator & in_data.comparator)
                                    : (prev_comparator & ~in_data.comparator);

  assign hist_ctrl = '{push: proc & push_c, fill: proc & fill_c};

  sbldc_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .ctrl (hist_ctrl),
    .iv   (iv_sel),
    .avg  (hist_avg)
  );

  always_comb begin
    step_reg_next        = step_reg;
    running_next         = running;
    blank_phase_next     = blank_phase;
    crossing_timer_next  = crossing_timer;
    overflow_seen_next   = overflow_seen;
    delay_count_next     = delay_count;
    delay_active_next    = delay_active;
    timeout_left_next    = timeout_left;
    duty_level_next      = duty_level;
    prev_comparator_next = prev_comparator;
    last_average_next    = last_average;
    push_c               = 1'b0;
    fill_c               = 1'b0;
    commutated_c         = 1'b0;
    timed_out_c          = 1'b0;

    case (sbldc_pkg::opcode_t'(in_data.opcode))
      sbldc_pkg::OP_FAST: begin
        crossing_timer_next  = timer_inc;
        overflow_seen_next   = overflow_hit;
        prev_comparator_next = in_data.comparator;
        // delay runs down before a crossing can reload it
        if (delay_active) begin
          if (delay_count <= sbldc_pkg::COUNT_W'(1)) begin
            if (blank_phase == sbldc_pkg::BL_WAIT) begin
              if (running) begin
                step_reg_next = (step_reg >= sbldc_pkg::LAST_STEP) ? '0 : step_reg + 1'b1;
                commutated_c  = 1'b1;
              end
              blank_phase_next = sbldc_pkg::BL_BLANK;
              delay_count_next = blank_ticks;
            end else begin
              blank_phase_next  = sbldc_pkg::BL_ARMED;
              delay_active_next = 1'b0;
              delay_count_next  = '0;
            end
          end else begin
            delay_count_next = delay_count - 1'b1;
          end
        end
        if (running && blank_phase_next == sbldc_pkg::BL_ARMED && zc_edge) begin
          push_c              = 1'b1;
          overflow_seen_next  = 1'b0;
          crossing_timer_next = '0;
          last_average_next   = hist_avg;
          if (hist_avg > delay_offset && hist_avg < sbldc_pkg::VALID_LIMIT) begin
            timeout_left_next = timeout_reload;
          end
          delay_count_next  = (hist_avg > delay_offset)
                            ? sbldc_pkg::COUNT_W'({hist_avg - delay_offset, 1'b0})
                            : sbldc_pkg::SHORT_DELAY;
          delay_active_next = 1'b1;
          blank_phase_next  = sbldc_pkg::BL_WAIT;
        end
      end
      sbldc_pkg::OP_SLOW: begin
        if (timeout_left != '0) begin
          timeout_left_next = timeout_left - 1'b1;
          if (timeout_left == sbldc_pkg::TOUT_W'(1)) begin
            running_next    = 1'b0;
            duty_level_next = '0;
            timed_out_c     = 1'b1;
          end
        end
        if (running_next) begin
          if (duty_level < target_duty) begin
            duty_level_next = duty_level + 1'b1;
          end else if (duty_level > target_duty) begin
            duty_level_next = duty_level - 1'b1;
          end
        end
      end
      sbldc_pkg::OP_START: begin
        if (!running && target_duty >= start_duty) begin
          fill_c            = 1'b1;
          duty_level_next   = start_duty;
          step_reg_next     = (in_data.start_step <= sbldc_pkg::LAST_STEP)
                            ? in_data.start_step : '0;
          running_next      = 1'b1;
          timeout_left_next = timeout_reload;
          blank_phase_next  = sbldc_pkg::BL_ARMED;
          delay_active_next = 1'b0;
          delay_count_next  = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data_next.step_now     = step_reg_next;
    res_data_next.high_side    = running_next ? sbldc_pkg::high_bits(step_reg_next) : '0;
    res_data_next.low_side     = running_next ? sbldc_pkg::low_bits(step_reg_next) : '0;
    res_data_next.duty         = duty_level_next;
    res_data_next.sense_phase  = sbldc_pkg::sense_bits(step_reg_next);
    res_data_next.is_running   = running_next;
    res_data_next.commutated   = commutated_c;
    res_data_next.timed_out    = timed_out_c;
    res_data_next.avg_interval = last_average_next;
    res_data_next.blank_state  = sbldc_pkg::blank_code(blank_phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg        <= '0;
      running         <= 1'b0;
      blank_phase     <= sbldc_pkg::BL_ARMED;
      crossing_timer  <= '0;
      overflow_seen   <= 1'b0;
      delay_count     <= '0;
      delay_active    <= 1'b0;
      timeout_left    <= '0;
      duty_level      <= '0;
      prev_comparator <= 1'b0;
      last_average    <= '0;
    end else if (proc) begin
      step_reg        <= step_reg_next;
      running         <= running_next;
      blank_phase     <= blank_phase_next;
      crossing_timer  <= crossing_timer_next;
      overflow_seen   <= overflow_seen_next;
      delay_count     <= delay_count_next;
      delay_active    <= delay_active_next;
      timeout_left    <= timeout_left_next;
      duty_level      <= duty_level_next;
      prev_comparator <= prev_comparator_next;
      last_average    <= last_average_next;
    end
  end

  `SBLDC_ASSERT_SAME(a_delay_tracks_blank, clk, rst, 1'b1,
    delay_active == (blank_phase != sbldc_pkg::BL_ARMED),
    "delay activity disagrees with blanking state")
  `SBLDC_ASSERT_SAME(a_step_in_range, clk, rst, 1'b1,
    step_reg <= sbldc_pkg::LAST_STEP, "commutation step out of range")
  `SBLDC_ASSERT_SAME(a_timeout_stops_drive, clk, rst, res_valid && res_data.timed_out,
    !res_data.is_running && res_data.duty == '0 && res_data.high_side == '0,
    "timeout beat still drives the motor")
  `SBLDC_ASSERT_NEXT(a_commutation_blanks, clk, rst, proc && commutated_c,
    blank_phase == sbldc_pkg::BL_BLANK, "commutation did not start blanking")
  `SBLDC_ASSERT_NEXT(a_start_runs, clk, rst,
    proc && in_data.opcode == sbldc_pkg::OP_START && !running && target_duty >= start_duty,
    running && timeout_left == timeout_reload, "accepted start did not run the motor")

endmodule

// File: sim/sensorless_bldc_commutation_tb.sv
// ----------------------------------------------------------------------------
// sensorless_bldc_commutation_tb
// Drives fast ticks, slow ticks and start commands into the commutation block
// and checks every output beat, field by field, against a cycle-free model of
// the step, blanking, interval history, stall timeout and duty ramp. A short
// table of directed beats runs at reset settings. It is followed by random
// segments under several register settings, including the extremes, and by
// long runs that wrap the crossing timer and the interval sum.
// ----------------------------------------------------------------------------
module sensorless_bldc_commutation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbldc_pkg::*;

  localparam int HIST_N      = HISTORY_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int IDLE_PCT    = 27;

  localparam logic [5:0][2:0] HS_OF_STEP = {3'd4, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1};
  localparam logic [5:0][2:0] LS_OF_STEP = {3'd2, 3'd1, 3'd1, 3'd4, 3'd4, 3'd2};
  localparam logic [5:0][1:0] SP_OF_STEP = {2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  localparam sbldc_out_t OUT_AT_RESET = '{sense_phase: 2'd2, default: '0};
  localparam sbldc_out_t OUT_STARTED = '{high_side: 3'b001, low_side: 3'b010,
                                         duty: START_DUTY_RST, sense_phase: 2'd2,
                                         is_running: 1'b1, default: '0};
  localparam sbldc_out_t OUT_RAMPED = '{high_side: 3'b001, low_side: 3'b010,
                                        duty: 8'd31, sense_phase: 2'd2,
                                        is_running: 1'b1, default: '0};

  typedef struct {
    opcode_t    op;
    logic       cmp;
    logic [2:0] st;
    logic       has_res;
    sbldc_out_t res;
  } dir_row_t;

  localparam int DIR_N = 13;

  dir_row_t dir_rows [DIR_N] = '{
    '{OP_NOP,   1'b0, 3'd0, 1'b1, OUT_AT_RESET},
    '{OP_SLOW,  1'b1, 3'd7, 1'b1, OUT_AT_RESET},
    '{OP_FAST,  1'b1, 3'd0, 1'b1, OUT_AT_RESET},
    '{OP_FAST,  1'b0, 3'd5, 1'b1, OUT_AT_RESET},
    '{OP_START, 1'b0, 3'd7, 1'b1, OUT_STARTED},
    '{OP_START, 1'b1, 3'd3, 1'b1, OUT_STARTED},
    '{OP_SLOW,  1'b0, 3'd0, 1'b1, OUT_RAMPED},
    '{OP_FAST,  1'b1, 3'd0, 1'b0, '0},
    '{OP_FAST,  1'b0, 3'd0, 1'b0, '0},
    '{OP_FAST,  1'b0, 3'd6, 1'b0, '0},
    '{OP_FAST,  1'b1, 3'd0, 1'b0, '0},
    '{OP_NOP,   1'b1, 3'd7, 1'b0, '0},
    '{OP_FAST,  1'b0, 3'd2, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sbldc_stream_if #(.payload_t(sbldc_in_t))  item_if ();
  sbldc_stream_if #(.payload_t(sbldc_out_t)) result_if ();

  sensorless_bldc_commutation dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // register copies
  logic [7:0]  cfg_target  = TARGET_DUTY_RST;
  logic [7:0]  cfg_start   = START_DUTY_RST;
  logic [7:0]  cfg_timeout = TIMEOUT_RELOAD_RST;
  logic [15:0] cfg_blank   = BLANK_TICKS_RST;
  logic [11:0] cfg_offset  = DELAY_OFFSET_RST;

  // motor state
  logic [2:0]      mot_step    = '0;
  logic            mot_running = 1'b0;
  logic [1:0]      mot_blank   = BLANK_CODE_ARMED;
  logic [IV_W-1:0] hist [HIST_N];
  logic [15:0]     hist_sum    = '0;
  logic [2:0]      hist_pos    = '0;
  logic [15:0]     xtimer      = '0;
  logic            ovf         = 1'b0;
  logic [15:0]     dly_cnt     = '0;
  logic            dly_on      = 1'b0;
  logic [7:0]      tmo_left    = '0;
  logic [7:0]      duty_q      = '0;
  logic            prev_cmp    = 1'b0;
  logic [11:0]     last_avg    = '0;

  sbldc_out_t pending_outputs [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = IDLE_PCT;
  int         recv_idle_pct  = IDLE_PCT;
  int         gap_left       = 0;
  logic       use_fixed      = 1'b0;
  sbldc_out_t fixed_res      = '0;

  function automatic sbldc_out_t commutation_predict(input sbldc_in_t b);
    sbldc_out_t r;
    logic zc_hit;
    logic [IV_W-1:0] iv;
    logic [11:0] avg;
    r = '0;
    case (b.opcode)
      OP_FAST: begin
        xtimer = xtimer + 1'b1;
        if (xtimer == '0) ovf = 1'b1;
        zc_hit = mot_step[0] ? (!prev_cmp && b.comparator) : (prev_cmp && !b.comparator);
        prev_cmp = b.comparator;
        if (dly_on) begin
          if (dly_cnt <= 16'd1) begin
            if (mot_blank == BLANK_CODE_WAIT) begin
              if (mot_running) begin
                mot_step = (mot_step >= LAST_STEP) ? 3'd0 : mot_step + 1'b1;
                r.commutated = 1'b1;
              end
              mot_blank = BLANK_CODE_BLANK;
              dly_cnt = cfg_blank;
            end else begin
              mot_blank = BLANK_CODE_ARMED;
              dly_on = 1'b0;
              dly_cnt = '0;
            end
          end else begin
            dly_cnt = dly_cnt - 1'b1;
          end
        end
        if (mot_running && mot_blank == BLANK_CODE_ARMED && zc_hit) begin
          if (ovf) begin
            ovf = 1'b0;
            iv = OVERFLOW_INTERVAL;
          end else begin
            iv = IV_W'(xtimer >> 1);
          end
          xtimer = '0;
          hist_sum = hist_sum - 16'(hist[hist_pos]) + 16'(iv);
          hist[hist_pos] = iv;
          hist_pos = hist_pos + 1'b1;
          avg = 12'(hist_sum / (2 * HIST_N));
          last_avg = avg;
          if (avg > cfg_offset && avg < VALID_LIMIT) tmo_left = cfg_timeout;
          dly_cnt = (avg > cfg_offset) ? {3'b000, avg - cfg_offset, 1'b0} : SHORT_DELAY;
          dly_on = 1'b1;
          mot_blank = BLANK_CODE_WAIT;
        end
      end
      OP_SLOW: begin
        if (tmo_left != '0) begin
          tmo_left = tmo_left - 1'b1;
          if (tmo_left == '0) begin
            mot_running = 1'b0;
            duty_q = '0;
            r.timed_out = 1'b1;
          end
        end
        if (mot_running) begin
          if (duty_q < cfg_target) duty_q = duty_q + 1'b1;
          else if (duty_q > cfg_target) duty_q = duty_q - 1'b1;
        end
      end
      OP_START: begin
        if (!mot_running && cfg_target >= cfg_start) begin
          duty_q = cfg_start;
          hist_sum = '0;
          foreach (hist[i]) begin
            hist[i] = START_INTERVAL;
            hist_sum = hist_sum + 16'(START_INTERVAL);
          end
          mot_step = (b.start_step <= LAST_STEP) ? b.start_step : 3'd0;
          mot_running = 1'b1;
          tmo_left = cfg_timeout;
          mot_blank = BLANK_CODE_ARMED;
          dly_on = 1'b0;
          dly_cnt = '0;
        end
      end
      default: ;
    endcase
    r.step_now     = mot_step;
    r.high_side    = mot_running ? HS_OF_STEP[mot_step] : 3'd0;
    r.low_side     = mot_running ? LS_OF_STEP[mot_step] : 3'd0;
    r.duty         = duty_q;
    r.sense_phase  = SP_OF_STEP[mot_step];
    r.is_running   = mot_running;
    r.avg_interval = last_avg;
    r.blank_state  = mot_blank;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : item_watch
    sbldc_out_t fresh;
    if (!rst && item_if.valid && item_if.ready) begin
      fresh = commutation_predict(item_if.data);
      pending_outputs.push_back(use_fixed ? fixed_res : fresh);
    end
  end

  always @(posedge clk) begin : result_watch
    sbldc_out_t got;
    sbldc_out_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (pending_outputs.size() == 0) begin
        report_mismatch("beat with nothing pending", 1, 0);
      end else begin
        want = pending_outputs.pop_front();
        if (got.step_now !== want.step_now)
          report_mismatch("step_now", got.step_now, want.step_now);
        if (got.high_side !== want.high_side)
          report_mismatch("high_side", got.high_side, want.high_side);
        if (got.low_side !== want.low_side)
          report_mismatch("low_side", got.low_side, want.low_side);
        if (got.duty !== want.duty)
          report_mismatch("duty", got.duty, want.duty);
        if (got.sense_phase !== want.sense_phase)
          report_mismatch("sense_phase", got.sense_phase, want.sense_phase);
        if (got.is_running !== want.is_running)
          report_mismatch("is_running", got.is_running, want.is_running);
        if (got.commutated !== want.commutated)
          report_mismatch("commutated", got.commutated, want.commutated);
        if (got.timed_out !== want.timed_out)
          report_mismatch("timed_out", got.timed_out, want.timed_out);
        if (got.avg_interval !== want.avg_interval)
          report_mismatch("avg_interval", got.avg_interval, want.avg_interval);
        if (got.blank_state !== want.blank_state)
          report_mismatch("blank_state", got.blank_state, want.blank_state);
      end
    end
  end

  always @(negedge clk) result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sensorless_bldc_commutation verification failed");
    $finish;
  end

  task automatic send_beat(input sbldc_in_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= b;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_index_t r, input logic [31:0] v);
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_TARGET_DUTY:    cfg_target  = v[7:0];
      REG_START_DUTY:     cfg_start   = v[7:0];
      REG_TIMEOUT_RELOAD: cfg_timeout = v[7:0];
      REG_BLANK_TICKS:    cfg_blank   = v[15:0];
      REG_DELAY_OFFSET:   cfg_offset  = v[11:0];
      default: ;
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== v) report_mismatch("register readback", prdata, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int target, input int start, input int tmo,
                               input int blank, input int offs);
    wait_drained();
    apb_write(REG_TARGET_DUTY, target);
    apb_write(REG_START_DUTY, start);
    apb_write(REG_TIMEOUT_RELOAD, tmo);
    apb_write(REG_BLANK_TICKS, blank);
    apb_write(REG_DELAY_OFFSET, offs);
  endtask

  // zc set: comparator edge of the current step's polarity, else a level that is never one
  function automatic sbldc_in_t fast_beat(input logic zc);
    sbldc_in_t b;
    b.opcode     = OP_FAST;
    b.comparator = zc ? mot_step[0] : !mot_step[0];
    b.start_step = 3'($urandom_range(0, 7));
    return b;
  endfunction

  function automatic sbldc_in_t random_beat(input int gap_max, output bit counts);
    sbldc_in_t b;
    int r;
    r = $urandom_range(0, 99);
    b.opcode     = OP_FAST;
    b.comparator = 1'($urandom_range(0, 1));
    b.start_step = 3'($urandom_range(0, 7));
    if ((!mot_running && r < 8) || r < 2) begin
      b.opcode = OP_START;
    end else if (r < 7) begin
      b.opcode = OP_SLOW;
    end else if (r < 8) begin
      b.opcode = OP_NOP;
    end else if (r >= 14) begin
      if (gap_left == 0) begin
        b = fast_beat(1'b1);
        gap_left = $urandom_range(1, gap_max);
      end else begin
        b = fast_beat(1'b0);
        gap_left--;
      end
    end
    counts = !(b.opcode == OP_NOP ||
               (b.opcode == OP_START && (mot_running || cfg_target < cfg_start)));
    return b;
  endfunction

  task automatic run_random(input int n, input int gap_max, input bit mid_pause);
    int done;
    bit counts;
    sbldc_in_t b;
    done = 0;
    while (done < n) begin
      b = random_beat(gap_max, counts);
      send_beat(b);
      if (counts) begin
        done++;
        if (mid_pause && done == n / 2) wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    sbldc_in_t b;
    foreach (hist[i]) hist[i] = '0;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.data = '0;
    result_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      b.opcode     = dir_rows[i].op;
      b.comparator = dir_rows[i].cmp;
      b.start_step = dir_rows[i].st;
      use_fixed = dir_rows[i].has_res;
      fixed_res = dir_rows[i].res;
      send_beat(b);
    end
    use_fixed = 1'b0;

    run_random(200, 300, 1'b0);
    apply_setting(255, 0, 1, 1, 0);
    run_random(200, 40, 1'b0);
    apply_setting(0, 255, 255, 65535, 4095);
    run_random(150, 40, 1'b0);
    apply_setting(0, 0, 255, 0, 4095);
    run_random(200, 20, 1'b0);
    for (int seg = 0; seg < 4; seg++) begin
      int target;
      target = $urandom_range(0, 255);
      apply_setting(target, $urandom_range(0, target), $urandom_range(1, 40),
                    $urandom_range(0, 30), $urandom_range(0, 20));
      send_idle_pct = (seg == 1) ? 0 : IDLE_PCT;
      recv_idle_pct = send_idle_pct;
      run_random(200, $urandom_range(10, 100), seg == 0);
    end

    // timer wrap, then two near-full intervals so the interval sum wraps
    apply_setting(200, 10, 255, 3, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    if (!mot_running) begin
      b.opcode     = OP_START;
      b.comparator = 1'b0;
      b.start_step = 3'($urandom_range(0, 5));
      send_beat(b);
    end
    while (!(ovf && mot_blank == BLANK_CODE_ARMED)) send_beat(fast_beat(1'b0));
    send_beat(fast_beat(1'b1));
    repeat (2) begin
      while (!(mot_blank == BLANK_CODE_ARMED && xtimer >= 16'd65532))
        send_beat(fast_beat(1'b0));
      send_beat(fast_beat(1'b1));
    end
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    run_random(150, 30, 1'b0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("sensorless_bldc_commutation verification clean");
    end else begin
      $display("sensorless_bldc_commutation verification failed");
    end
    $finish;
  end

endmodule
